// ----- rtl/core/euler_angle_vector_rotator_assert.svh -----
// Assertion macros for the checker file of the rotator.
`ifndef EULER_ANGLE_VECTOR_ROTATOR_ASSERT_SVH
`define EULER_ANGLE_VECTOR_ROTATOR_ASSERT_SVH

// Property checked on the rising edge, switched off while reset is held.
`define EAVR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define EAVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/eavr_pkg.sv -----
`default_nettype none

package eavr_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int ANG_W   = 16;
  localparam int FRAC_W  = 16;

  // Sine and cosine in signed 1.16, magnitude up to one.
  localparam int TRIG_W = FRAC_W + 2;
  localparam int UNIT_W = FRAC_W + 1;

  // Rotation products and their pairwise sums.
  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = SUM_W - FRAC_W;

  // Angle split: quadrant, coarse table index, fine table index.
  localparam int Q_W      = 2;
  localparam int HI_W     = 7;
  localparam int LO_W     = ANG_W - Q_W - HI_W;
  localparam int HI_DEPTH = 1 << HI_W;
  localparam int LO_DEPTH = 1 << LO_W;

  // Table entries carry 38 fractional bits.
  localparam int TAB_FRAC = 38;
  localparam int SA_W     = TAB_FRAC + 1;
  localparam int SB_W     = 32;
  localparam int EB_W     = 25;
  localparam int SPLIT    = 19;
  localparam int HIP_W    = SA_W - SPLIT;
  localparam int FULL_W   = 2 * TAB_FRAC + 3;
  localparam int RSH      = 2 * TAB_FRAC - FRAC_W;

  // Pipeline depth of the trig unit and of the whole block.
  localparam int SC_DEPTH   = 4;
  localparam int PIPE_DEPTH = 10;

  // Q62 constants used while building the tables.
  localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PIO2_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [Q_W-1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [ANG_W-1:0]          yaw_angle;
    logic [ANG_W-1:0]          pitch_angle;
    logic [ANG_W-1:0]          roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_x;
    logic signed [COORD_W-1:0] rot_y;
    logic signed [COORD_W-1:0] rot_z;
  } out_item_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] c;
  } q62_pair_t;

  typedef logic [SA_W-1:0] hi_tab_t [HI_DEPTH];
  typedef logic [SB_W-1:0] sb_tab_t [LO_DEPTH];
  typedef logic [EB_W-1:0] eb_tab_t [LO_DEPTH];

  // (a * b) >> 62, truncated.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Angle addition: rotate pair p by the angle held in step.
  function automatic q62_pair_t rot_q62(input q62_pair_t p, input q62_pair_t step);
    q62_pair_t r;
    r.s = mul_q62(p.s, step.c) + mul_q62(p.c, step.s);
    r.c = mul_q62(p.c, step.c) - mul_q62(p.s, step.s);
    return r;
  endfunction

  // Sine and cosine of one fine step, a short series is exact at Q62.
  function automatic q62_pair_t fine_step();
    q62_pair_t r;
    logic [63:0] d;
    logic [63:0] d2;
    d   = PIO2_Q62 >> (ANG_W - Q_W);
    d2  = mul_q62(d, d);
    r.s = d - mul_q62(d2, d) / 6;
    r.c = ONE_Q62 - (d2 >> 1) + mul_q62(d2, d2) / 24;
    return r;
  endfunction

  function automatic q62_pair_t coarse_step();
    q62_pair_t p;
    q62_pair_t f;
    p = '{s: 64'd0, c: ONE_Q62};
    f = fine_step();
    for (int i = 0; i < LO_DEPTH; i++) p = rot_q62(p, f);
    return p;
  endfunction

  // Round a Q62 value to the table format.
  function automatic logic [SA_W-1:0] to_tab(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (61 - TAB_FRAC))) >> (62 - TAB_FRAC);
    return r[SA_W-1:0];
  endfunction

  function automatic hi_tab_t build_hi(input logic want_sin);
    hi_tab_t   t;
    q62_pair_t p;
    q62_pair_t st;
    p  = '{s: 64'd0, c: ONE_Q62};
    st = coarse_step();
    for (int i = 0; i < HI_DEPTH; i++) begin
      t[i] = want_sin ? to_tab(p.s) : to_tab(p.c);
      p    = rot_q62(p, st);
    end
    return t;
  endfunction

  function automatic sb_tab_t build_sb();
    sb_tab_t         t;
    q62_pair_t       p;
    q62_pair_t       st;
    logic [SA_W-1:0] v;
    p  = '{s: 64'd0, c: ONE_Q62};
    st = fine_step();
    for (int i = 0; i < LO_DEPTH; i++) begin
      v    = to_tab(p.s);
      t[i] = v[SB_W-1:0];
      p    = rot_q62(p, st);
    end
    return t;
  endfunction

  // One minus the cosine of the fine angle.
  function automatic eb_tab_t build_eb();
    eb_tab_t         t;
    q62_pair_t       p;
    q62_pair_t       st;
    logic [SA_W-1:0] v;
    p  = '{s: 64'd0, c: ONE_Q62};
    st = fine_step();
    for (int i = 0; i < LO_DEPTH; i++) begin
      v    = (SA_W'(1) << TAB_FRAC) - to_tab(p.c);
      t[i] = v[EB_W-1:0];
      p    = rot_q62(p, st);
    end
    return t;
  endfunction

  localparam hi_tab_t SIN_HI_TAB = build_hi(1'b1);
  localparam hi_tab_t COS_HI_TAB = build_hi(1'b0);
  localparam sb_tab_t SIN_LO_TAB = build_sb();
  localparam eb_tab_t EPS_LO_TAB = build_eb();

  // Round half up at 16 fractional bits, then saturate to a coordinate.
  function automatic logic signed [COORD_W-1:0] sat_round(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] t;
    logic signed [QUO_W-1:0] q;
    logic signed [QUO_W-1:0] sat_hi;
    logic signed [QUO_W-1:0] sat_lo;
    sat_hi = {{(QUO_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    sat_lo = ~sat_hi;
    t = sum + $signed({{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    q = t[SUM_W-1:FRAC_W];
    if (q > sat_hi) return sat_hi[COORD_W-1:0];
    if (q < sat_lo) return sat_lo[COORD_W-1:0];
    return q[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/eavr_if.sv -----
`default_nettype none

// Input channel: one point and its three angles per item.
interface eavr_in_if;
  import eavr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one rotated point per item.
interface eavr_out_if;
  import eavr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/eavr_sincos.sv -----
`default_nettype none

module eavr_sincos
  import eavr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [SC_DEPTH-1:0]    stage_en,
  input  wire logic [ANG_W-1:0]       ang,
  output logic      signed [TRIG_W-1:0] sin_o,
  output logic      signed [TRIG_W-1:0] cos_o
);

  logic [HI_W-1:0] hi_idx;
  logic [LO_W-1:0] lo_idx;

  quad_t           q0_r;
  logic [SA_W-1:0] sa0_r;
  logic [SA_W-1:0] ca0_r;
  logic [SB_W-1:0] sb0_r;
  logic [EB_W-1:0] eb0_r;

  quad_t                       q1_r;
  logic [SA_W-1:0]             sa1_r;
  logic [SA_W-1:0]             ca1_r;
  logic [HIP_W+EB_W-1:0]       se_hi_r;
  logic [SPLIT+EB_W-1:0]       se_lo_r;
  logic [HIP_W+EB_W-1:0]       ce_hi_r;
  logic [SPLIT+EB_W-1:0]       ce_lo_r;
  logic [HIP_W+SB_W-1:0]       cs_hi_r;
  logic [SPLIT+SB_W-1:0]       cs_lo_r;
  logic [HIP_W+SB_W-1:0]       ss_hi_r;
  logic [SPLIT+SB_W-1:0]       ss_lo_r;

  logic [FULL_W-1:0] se_full;
  logic [FULL_W-1:0] ce_full;
  logic [FULL_W-1:0] cs_full;
  logic [FULL_W-1:0] ss_full;
  logic [FULL_W-1:0] sin_acc;
  logic [FULL_W-1:0] cos_acc;
  logic [FULL_W-1:0] half_lsb;

  quad_t             q2_r;
  logic [UNIT_W-1:0] su2_r;
  logic [UNIT_W-1:0] cu2_r;

  logic signed [TRIG_W-1:0] s_pos;
  logic signed [TRIG_W-1:0] c_pos;
  logic signed [TRIG_W-1:0] s3_nxt;
  logic signed [TRIG_W-1:0] c3_nxt;
  logic signed [TRIG_W-1:0] s3_r;
  logic signed [TRIG_W-1:0] c3_r;

  assign hi_idx = ang[ANG_W-Q_W-1 -: HI_W];
  assign lo_idx = ang[LO_W-1:0];

  // Table look-up for the coarse and fine parts of the angle.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      q0_r  <= quad_t'(ang[ANG_W-1 -: Q_W]);
      sa0_r <= SIN_HI_TAB[hi_idx];
      ca0_r <= COS_HI_TAB[hi_idx];
      sb0_r <= SIN_LO_TAB[lo_idx];
      eb0_r <= EPS_LO_TAB[lo_idx];
    end
  end

  // Partial products, the coarse entries split in two halves.
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q1_r    <= q0_r;
      sa1_r   <= sa0_r;
      ca1_r   <= ca0_r;
      se_hi_r <= sa0_r[SA_W-1:SPLIT] * eb0_r;
      se_lo_r <= sa0_r[SPLIT-1:0] * eb0_r;
      ce_hi_r <= ca0_r[SA_W-1:SPLIT] * eb0_r;
      ce_lo_r <= ca0_r[SPLIT-1:0] * eb0_r;
      cs_hi_r <= ca0_r[SA_W-1:SPLIT] * sb0_r;
      cs_lo_r <= ca0_r[SPLIT-1:0] * sb0_r;
      ss_hi_r <= sa0_r[SA_W-1:SPLIT] * sb0_r;
      ss_lo_r <= sa0_r[SPLIT-1:0] * sb0_r;
    end
  end

  // Angle addition with cos(b) = 1 - eps, rounded to 16 fractional bits.
  always_comb begin
    se_full  = (FULL_W'(se_hi_r) << SPLIT) + FULL_W'(se_lo_r);
    ce_full  = (FULL_W'(ce_hi_r) << SPLIT) + FULL_W'(ce_lo_r);
    cs_full  = (FULL_W'(cs_hi_r) << SPLIT) + FULL_W'(cs_lo_r);
    ss_full  = (FULL_W'(ss_hi_r) << SPLIT) + FULL_W'(ss_lo_r);
    half_lsb = FULL_W'(1) << (RSH - 1);
    sin_acc  = (FULL_W'(sa1_r) << TAB_FRAC) + cs_full - se_full + half_lsb;
    cos_acc  = (FULL_W'(ca1_r) << TAB_FRAC) - ce_full - ss_full + half_lsb;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      q2_r  <= q1_r;
      su2_r <= sin_acc[RSH +: UNIT_W];
      cu2_r <= cos_acc[RSH +: UNIT_W];
    end
  end

  // Quadrant mapping of the first-quadrant pair.
  always_comb begin
    s_pos = $signed({1'b0, su2_r});
    c_pos = $signed({1'b0, cu2_r});
    case (q2_r)
      QUAD_0: begin
        s3_nxt = s_pos;
        c3_nxt = c_pos;
      end
      QUAD_1: begin
        s3_nxt = c_pos;
        c3_nxt = -s_pos;
      end
      QUAD_2: begin
        s3_nxt = -s_pos;
        c3_nxt = -c_pos;
      end
      QUAD_3: begin
        s3_nxt = -c_pos;
        c3_nxt = s_pos;
      end
      default: begin
        s3_nxt = s_pos;
        c3_nxt = c_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_r <= s3_nxt;
      c3_r <= c3_nxt;
    end
  end

  assign sin_o = s3_r;
  assign cos_o = c3_r;

endmodule

`default_nettype wire

// ----- rtl/core/euler_angle_vector_rotator.sv -----
`default_nettype none

// Rotates a signed Q16.16 point by roll about Y, then pitch about X, then yaw
// about Z, with binary angles of 65536 steps per turn. Each axis result of each
// rotation is rounded half up at 16 fractional bits and saturated to 32 bits.
// The block is a ten-stage pipeline without state: it takes one item per clock
// unless a stall at the output has filled every stage. The first four stages
// form sine and cosine of all three angles from four 128-entry tables (coarse
// sine and cosine, fine sine and fine one-minus-cosine) and an angle addition;
// each rotation then takes one multiply stage and one round-and-saturate stage.
// Every stage holds its item while the one after it is full and holding, so a
// stall at the output fills the bubbles before it reaches the input.
module euler_angle_vector_rotator
  import eavr_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  eavr_in_if.sink   in_ch,
  eavr_out_if.source out_ch
);

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  logic [PIPE_DEPTH-1:0] en;

  logic signed [COORD_W-1:0] px_r [SC_DEPTH];
  logic signed [COORD_W-1:0] py_r [SC_DEPTH];
  logic signed [COORD_W-1:0] pz_r [SC_DEPTH];

  trig_t roll_t;
  trig_t pitch_t;
  trig_t yaw_t;

  // Roll stages.
  logic signed [PROD_W-1:0]  m4_xc_r, m4_zs_r, m4_xs_r, m4_zc_r;
  logic signed [COORD_W-1:0] y4_r, y5_r;
  logic signed [COORD_W-1:0] x5_r, z5_r;
  trig_t                     pitch4_r, pitch5_r;
  trig_t                     yaw4_r, yaw5_r, yaw6_r, yaw7_r;

  // Pitch stages.
  logic signed [PROD_W-1:0]  m6_yc_r, m6_zs_r, m6_ys_r, m6_zc_r;
  logic signed [COORD_W-1:0] x6_r, x7_r;
  logic signed [COORD_W-1:0] y7_r, z7_r;

  // Yaw stages.
  logic signed [PROD_W-1:0]  m8_xc_r, m8_ys_r, m8_xs_r, m8_yc_r;
  logic signed [COORD_W-1:0] z8_r;
  logic signed [COORD_W-1:0] x9_r, y9_r, z9_r;

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_ch.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    if (en[0]) begin
      v_nxt[0] = in_ch.valid;
    end else begin
      v_nxt[0] = v_r[0];
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = en[0];

  // Sine and cosine of the three angles.
  eavr_sincos u_roll (
    .clk      (clk),
    .stage_en (en[SC_DEPTH-1:0]),
    .ang      (in_ch.data.roll_angle),
    .sin_o    (roll_t.s),
    .cos_o    (roll_t.c)
  );

  eavr_sincos u_pitch (
    .clk      (clk),
    .stage_en (en[SC_DEPTH-1:0]),
    .ang      (in_ch.data.pitch_angle),
    .sin_o    (pitch_t.s),
    .cos_o    (pitch_t.c)
  );

  eavr_sincos u_yaw (
    .clk      (clk),
    .stage_en (en[SC_DEPTH-1:0]),
    .ang      (in_ch.data.yaw_angle),
    .sin_o    (yaw_t.s),
    .cos_o    (yaw_t.c)
  );

  // The coordinates wait alongside the trig unit.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r[0] <= in_ch.data.pos_x;
      py_r[0] <= in_ch.data.pos_y;
      pz_r[0] <= in_ch.data.pos_z;
    end
    for (int k = 1; k < SC_DEPTH; k++) begin
      if (en[k]) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
        pz_r[k] <= pz_r[k-1];
      end
    end
  end

  // Roll about Y: products, then x' = xc + zs and z' = zc - xs.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      m4_xc_r  <= px_r[3] * roll_t.c;
      m4_zs_r  <= pz_r[3] * roll_t.s;
      m4_xs_r  <= px_r[3] * roll_t.s;
      m4_zc_r  <= pz_r[3] * roll_t.c;
      y4_r     <= py_r[3];
      pitch4_r <= pitch_t;
      yaw4_r   <= yaw_t;
    end
    if (en[5]) begin
      x5_r     <= sat_round(SUM_W'(m4_xc_r) + SUM_W'(m4_zs_r));
      z5_r     <= sat_round(SUM_W'(m4_zc_r) - SUM_W'(m4_xs_r));
      y5_r     <= y4_r;
      pitch5_r <= pitch4_r;
      yaw5_r   <= yaw4_r;
    end
  end

  // Pitch about X: y' = yc - zs and z' = ys + zc.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      m6_yc_r <= y5_r * pitch5_r.c;
      m6_zs_r <= z5_r * pitch5_r.s;
      m6_ys_r <= y5_r * pitch5_r.s;
      m6_zc_r <= z5_r * pitch5_r.c;
      x6_r    <= x5_r;
      yaw6_r  <= yaw5_r;
    end
    if (en[7]) begin
      y7_r   <= sat_round(SUM_W'(m6_yc_r) - SUM_W'(m6_zs_r));
      z7_r   <= sat_round(SUM_W'(m6_ys_r) + SUM_W'(m6_zc_r));
      x7_r   <= x6_r;
      yaw7_r <= yaw6_r;
    end
  end

  // Yaw about Z: x' = xc - ys and y' = xs + yc.
  always_ff @(posedge clk) begin
    if (en[8]) begin
      m8_xc_r <= x7_r * yaw7_r.c;
      m8_ys_r <= y7_r * yaw7_r.s;
      m8_xs_r <= x7_r * yaw7_r.s;
      m8_yc_r <= y7_r * yaw7_r.c;
      z8_r    <= z7_r;
    end
    if (en[9]) begin
      x9_r <= sat_round(SUM_W'(m8_xc_r) - SUM_W'(m8_ys_r));
      y9_r <= sat_round(SUM_W'(m8_xs_r) + SUM_W'(m8_yc_r));
      z9_r <= z8_r;
    end
  end

  assign out_ch.valid      = v_r[PIPE_DEPTH-1];
  assign out_ch.data.rot_x = x9_r;
  assign out_ch.data.rot_y = y9_r;
  assign out_ch.data.rot_z = z9_r;

endmodule

`default_nettype wire

// ----- rtl/core/eavr_checker.sv -----
`default_nettype none

`include "euler_angle_vector_rotator_assert.svh"

module eavr_checker
  import eavr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_acc;
  logic             out_acc;

  // Items accepted but not yet delivered.
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `EAVR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `EAVR_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")
  `EAVR_ASSERT(a_no_invent, clk, rst_n, out_valid |-> cnt_r != '0, "result without an accepted item")
  `EAVR_ASSERT(a_bound, clk, rst_n, cnt_r <= CNT_W'(PIPE_DEPTH), "more items in flight than stages")
  `EAVR_ASSERT_ALWAYS(a_ready_why, clk, rst_n && !in_ready |-> out_valid && !out_ready, "input refused without an output stall")

endmodule

bind euler_angle_vector_rotator eavr_checker u_eavr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ----- tb/euler_angle_vector_rotator_tb.sv -----
`timescale 1ns / 1ps

module euler_angle_vector_rotator_tb;
  import eavr_pkg::*;

  localparam int N_RANDOM   = 1430;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYC  = 4 * PIPE_DEPTH;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  logic clk;
  logic rst_n;

  eavr_in_if  in_ch ();
  eavr_out_if out_ch ();

  euler_angle_vector_rotator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t  pending_points[$];
  out_item_t rotated_expected[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  int        send_gap;
  int        stall_left;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Q62 product, truncated.
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Sine and cosine of a binary angle, rounded to signed 1.16.
  function automatic void angle_trig(input logic [ANG_W-1:0] ang,
                                     output longint s, output longint c);
    quad_t       quad;
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] s_acc;
    logic [63:0] c_acc;
    longint      s0;
    longint      c0;
    quad  = quad_t'(ang[ANG_W-1 -: 2]);
    theta = q62_mul({ang[ANG_W-3:0], 48'd0}, HALF_PI_Q62);
    term  = theta;
    s_acc = 64'd0;
    c_acc = 64'd1 << 62;
    for (int n = 1; n <= 32; n++) begin
      if (n > 1) term = q62_mul(term, theta) / n;
      case (n % 4)
        1: s_acc += term;
        2: c_acc -= term;
        3: s_acc -= term;
        default: c_acc += term;
      endcase
    end
    s0 = longint'((s_acc + (64'd1 << 45)) >> 46);
    c0 = longint'((c_acc + (64'd1 << 45)) >> 46);
    case (quad)
      QUAD_0: begin s = s0;  c = c0;  end
      QUAD_1: begin s = c0;  c = -s0; end
      QUAD_2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  // Two-term product sum, rounded half up at 16 fractional bits and saturated.
  function automatic longint rotate_axis(input longint a, input longint ka,
                                         input longint b, input longint kb);
    longint acc;
    acc = (a * ka + b * kb + 64'sd32768) >>> 16;
    if (acc > 64'sd2147483647) return 64'sd2147483647;
    if (acc < -64'sd2147483648) return -64'sd2147483648;
    return acc;
  endfunction

  // Roll about Y, then pitch about X, then yaw about Z.
  function automatic out_item_t rotate_point(input in_item_t p);
    out_item_t r;
    longint    x, y, z, nx, ny, s, c;
    x = p.pos_x;
    y = p.pos_y;
    z = p.pos_z;
    angle_trig(p.roll_angle, s, c);
    nx = rotate_axis(x, c, z, s);
    z  = rotate_axis(x, -s, z, c);
    x  = nx;
    angle_trig(p.pitch_angle, s, c);
    ny = rotate_axis(y, c, z, -s);
    z  = rotate_axis(y, s, z, c);
    y  = ny;
    angle_trig(p.yaw_angle, s, c);
    nx = rotate_axis(x, c, y, -s);
    y  = rotate_axis(x, s, y, c);
    x  = nx;
    r.rot_x = x[COORD_W-1:0];
    r.rot_y = y[COORD_W-1:0];
    r.rot_z = z[COORD_W-1:0];
    return r;
  endfunction

  function automatic in_item_t make_point(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [15:0] yaw,
                                          input logic [15:0] pitch, input logic [15:0] roll);
    in_item_t p;
    p.pos_x       = x;
    p.pos_y       = y;
    p.pos_z       = z;
    p.yaw_angle   = yaw;
    p.pitch_angle = pitch;
    p.roll_angle  = roll;
    return p;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 70000)
                                     : 32'h8000_0000 + $urandom_range(0, 70000);
      1: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3) << 14);
      1: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver: presents the pending items, with random bursts of idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_points.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= $urandom_range(1, 16) - 1;
      end else if (pending_points.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_points.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, in random bursts, none near the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (pending_points.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 16) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Each accepted item produces one expected rotated point.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rotated_expected.push_back(rotate_point(in_ch.data));
      n_sent <= n_sent + 1;
    end
  end

  // Monitor: compares every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rotated_expected.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time,
                 out_ch.data.rot_x, out_ch.data.rot_y, out_ch.data.rot_z);
        n_errors++;
      end else begin
        want = rotated_expected.pop_front();
        n_checked++;
        if (out_ch.data.rot_x !== want.rot_x) begin
          $display("%0t: rot_x expected %h actual %h", $time, want.rot_x, out_ch.data.rot_x);
          n_errors++;
        end
        if (out_ch.data.rot_y !== want.rot_y) begin
          $display("%0t: rot_y expected %h actual %h", $time, want.rot_y, out_ch.data.rot_y);
          n_errors++;
        end
        if (out_ch.data.rot_z !== want.rot_z) begin
          $display("%0t: rot_z expected %h actual %h", $time, want.rot_z, out_ch.data.rot_z);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    n_errors    = 0;
    n_checked   = 0;
    n_sent      = 0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;

    // Directed points: zero, extremes, quarter turns and saturating rotations.
    pending_points.push_back(make_point(0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0));
    pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        16'h2000, 16'h2000, 16'h2000));
    pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        16'hE000, 16'h6000, 16'hA000));
    pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF));
    for (int q = 0; q < 4; q++) begin
      pending_points.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                          16'(q << 14), 0, 0));
      pending_points.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                          0, 16'(q << 14), 0));
      pending_points.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                          0, 0, 16'(q << 14)));
    end
    pending_points.push_back(make_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001,
                                        16'h0001, 16'h3FFF, 16'h4001));
    pending_points.push_back(make_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                        16'h5555, 16'hAAAA, 16'h8000));
    pending_points.push_back(make_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                                        16'hAAAA, 16'h5555, 16'h7FFF));
    for (int i = 0; i < N_RANDOM; i++)
      pending_points.push_back(make_point(random_coord(), random_coord(), random_coord(),
                                          random_angle(), random_angle(), random_angle()));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every result to come out.
    wait (pending_points.size() == 0 && !in_ch.valid);
    wait (rotated_expected.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Rotated %0d points (directed extremes, quarter turns, random coordinates",
             n_sent);
    $display("and angles, with idling on both sides); %0d results checked.", n_checked);
    if (n_errors == 0 && rotated_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", rotated_expected.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
